FILE: rtl/fdm_pkg.sv
`default_nettype none

package fdm_pkg;

    // widths of the item and result fields
    localparam int unsigned PIX_W = 8;
    localparam int unsigned NUM_W = 31;
    localparam int unsigned SUM_W = 29;
    localparam int unsigned DIM_W = 11;

    // stream payload widths, padded to whole bytes
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 96;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd2;

    // configuration reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd720;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic             FMT_YUV420   = 1'b0;
    localparam logic             FMT_RGB24    = 1'b1;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_SEQ_FAIL = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // one byte on its way from the scan stage to the accumulate stage
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [NUM_W-1:0] frame;
        logic             counted;
        logic             odd_row;
        logic             use_prev;
        logic             eof;
        logic             mismatch;
    } fdm_item_t;

endpackage

`default_nettype wire

FILE: rtl/fdm_frame_store.sv
`default_nettype none

module fdm_frame_store #(
    parameter int unsigned DEPTH  = 3145728,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [7:0]        wr_data,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    // single port, read-first: the read returns the byte of the previous frame
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[addr];
        end
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fdm_scan.sv
`default_nettype none

module fdm_scan
    import fdm_pkg::*;
#(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned MAX_HEIGHT  = 1024,
    parameter int unsigned STORE_BYTES = 3145728,
    parameter int unsigned ADDR_W      = $clog2(STORE_BYTES)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 take,
    input  wire logic [PIX_W-1:0]     pix,
    input  wire logic [NUM_W-1:0]     num,
    output logic                      item_valid,
    output fdm_item_t                 item,
    output logic                      store_rd,
    output logic                      store_wr,
    output logic [ADDR_W-1:0]         store_addr,
    output logic                      halted
);

    localparam int unsigned FRAME_MAX = 3 * MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned POS_LIM   = (FRAME_MAX > STORE_BYTES) ? FRAME_MAX : STORE_BYTES;
    localparam int unsigned POS_W     = $clog2(POS_LIM + 1);
    localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW        = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CWW       = (WW > DIM_W) ? WW : DIM_W;
    localparam int unsigned CHW       = (HW > DIM_W) ? HW : DIM_W;
    localparam int unsigned COL_W     = $clog2(3 * MAX_WIDTH + 1);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             format_reg;

    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [HW-1:0]    row_reg,    row_next;
    logic [COL_W-1:0] col_reg,    col_next;
    logic             chroma_reg, chroma_next;
    logic             first_reg,  first_next;
    logic [NUM_W-1:0] exp_reg,    exp_next;
    logic             halt_reg,   halt_next;

    logic [CWW-1:0]   w_ext;
    logic [CHW-1:0]   h_ext;
    logic [WW-1:0]    w;
    logic [HW-1:0]    h;
    logic [WW-1:0]    half;
    logic             rgb;
    logic [COL_W-1:0] rowlen;
    logic             counted;
    logic [COL_W-1:0] col_inc;
    logic [HW-1:0]    row_inc;
    logic             col_end;
    logic             row_end;
    logic             eof;
    logic             pos0;
    logic [NUM_W-1:0] exp_eff;
    logic             mismatch;
    logic             in_store;
    logic             live;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            format_reg <= FMT_YUV420;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                CFG_PIXEL_FORMAT: format_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped frame dimensions
    always_comb begin
        w_ext = CWW'(width_reg);
        h_ext = CHW'(height_reg);
        if (w_ext < CWW'(2)) begin
            w = WW'(2);
        end else if (w_ext > CWW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = w_ext[WW-1:0];
        end
        if (h_ext < CHW'(2)) begin
            h = HW'(2);
        end else if (h_ext > CHW'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = h_ext[HW-1:0];
        end
    end

    // row length and counted flag for the current region
    always_comb begin
        rgb  = (format_reg == FMT_RGB24);
        half = w >> 1;
        if (rgb) begin
            rowlen  = (COL_W'(w) << 1) + COL_W'(w);
            counted = 1'b1;
        end else if (!chroma_reg) begin
            rowlen  = COL_W'(w);
            counted = 1'b1;
        end else begin
            rowlen  = COL_W'(half) + COL_W'(w[0] & row_reg[0]);
            counted = (col_reg < COL_W'(half));
        end
    end

    // frame sequencing and position walk
    always_comb begin
        live     = take && !halt_reg;
        pos0     = (pos_reg == '0);
        exp_eff  = (first_reg && pos0) ? num : exp_reg;
        mismatch = pos0 && (num != exp_eff);
        in_store = (pos_reg < POS_W'(STORE_BYTES));
        col_inc  = col_reg + COL_W'(1);
        row_inc  = row_reg + HW'(1);
        col_end  = (col_inc >= rowlen);
        row_end  = col_end && (row_inc >= h);
        eof      = row_end && (rgb || chroma_reg);

        pos_next    = pos_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        chroma_next = chroma_reg;
        first_next  = first_reg;
        exp_next    = exp_reg;
        halt_next   = halt_reg;

        if (live) begin
            if (mismatch) begin
                halt_next = 1'b1;
            end else begin
                exp_next = exp_eff;
                pos_next = pos_reg + POS_W'(1);
                if (eof) begin
                    pos_next    = '0;
                    row_next    = '0;
                    col_next    = '0;
                    chroma_next = 1'b0;
                    first_next  = 1'b0;
                    exp_next    = exp_eff + NUM_W'(1);
                end else if (row_end) begin
                    row_next    = '0;
                    col_next    = '0;
                    chroma_next = 1'b1;
                end else if (col_end) begin
                    row_next = row_inc;
                    col_next = '0;
                end else begin
                    col_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            chroma_reg <= 1'b0;
            first_reg  <= 1'b1;
            exp_reg    <= '0;
            halt_reg   <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            chroma_reg <= chroma_next;
            first_reg  <= first_next;
            exp_reg    <= exp_next;
            halt_reg   <= halt_next;
        end
    end

    // store access and item handed to the accumulate stage
    always_comb begin
        store_addr    = pos_reg[ADDR_W-1:0];
        store_rd      = live && !mismatch && in_store;
        store_wr      = live && !mismatch && in_store;
        item_valid    = live;
        item.pix      = pix;
        item.frame    = exp_eff;
        item.counted  = counted;
        item.odd_row  = row_reg[0];
        item.use_prev = !first_reg && in_store;
        item.eof      = eof;
        item.mismatch = mismatch;
        halted        = halt_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/field_delta_measure_core.sv
`default_nettype none

// channel | dir | handshake         | payload (lowest bit first)
// --------+-----+-------------------+-----------------------------------------------------
// s_      | in  | s_tvalid/s_tready | tdata: pixel_byte[7:0], frame_number[38:8]
// m_      | out | m_tvalid/m_tready | tdata: result_frame, even_delta, odd_delta; tuser: status
// cfg_    | in  | cfg_we            | cfg_index selects register, cfg_data value
//
// One byte per cycle while input is not stalled: a byte reads and rewrites its frame store
// entry in the cycle it is accepted, and its difference is summed in the next cycle. A result
// is formed in the accumulate stage; results wait in a two-entry output buffer, and input
// stalls only while the buffer could not take one more result in the next cycle.
// Reset clears counters, sums and flags; the frame store is not cleared, the first frame
// is compared with itself. After a sequence error the block swallows every byte until reset.

module field_delta_measure_core
    import fdm_pkg::*;
#(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned MAX_HEIGHT  = 1024,
    parameter int unsigned STORE_BYTES = 3145728
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // pixel_byte, frame_number, zero pad
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // result_frame, even_delta, odd_delta, pad
    output logic [0:0]                m_tuser    // status
);

    localparam int unsigned ADDR_W = $clog2(STORE_BYTES);

    logic              take;
    logic              item_valid;
    fdm_item_t         item;
    logic              store_rd;
    logic              store_wr;
    logic [ADDR_W-1:0] store_addr;
    logic [PIX_W-1:0]  rd_data;
    logic              halted;

    logic              s1_valid_reg;
    fdm_item_t         s1_item_reg;
    logic              s1_res;

    logic [SUM_W-1:0]  even_reg, even_next;
    logic [SUM_W-1:0]  odd_reg,  odd_next;
    logic [PIX_W-1:0]  prev;
    logic [PIX_W-1:0]  diff;
    logic [SUM_W:0]    even_add;
    logic [SUM_W:0]    odd_add;
    logic [SUM_W-1:0]  even_sat;
    logic [SUM_W-1:0]  odd_sat;

    logic [NUM_W-1:0]  res_frame;
    logic [SUM_W-1:0]  res_even;
    logic [SUM_W-1:0]  res_odd;
    logic              res_status;
    logic              m_pop;
    logic [1:0]        res_occ;

    logic              m_valid_reg;
    logic [NUM_W-1:0]  m_frame_reg;
    logic [SUM_W-1:0]  m_even_reg;
    logic [SUM_W-1:0]  m_odd_reg;
    logic              m_status_reg;

    logic              sk_valid_reg;
    logic [NUM_W-1:0]  sk_frame_reg;
    logic [SUM_W-1:0]  sk_even_reg;
    logic [SUM_W-1:0]  sk_odd_reg;
    logic              sk_status_reg;

    // input side takes a transaction when the output buffer keeps room for one result, or once halted
    always_comb begin
        m_pop    = m_valid_reg && m_tready;
        res_occ  = 2'(m_valid_reg) + 2'(sk_valid_reg) + 2'(s1_res) - 2'(m_pop);
        s_tready = halted || (res_occ <= 2'd1);
        take     = s_tvalid && s_tready;
    end

    fdm_scan #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .pix        (s_tdata[PIX_W-1:0]),
        .num        (s_tdata[PIX_W+NUM_W-1:PIX_W]),
        .item_valid (item_valid),
        .item       (item),
        .store_rd   (store_rd),
        .store_wr   (store_wr),
        .store_addr (store_addr),
        .halted     (halted)
    );

    fdm_frame_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (store_rd),
        .wr_en   (store_wr),
        .addr    (store_addr),
        .wr_data (item.pix),
        .rd_data (rd_data)
    );

    // accumulate stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid) begin
            s1_item_reg <= item;
        end
    end

    // absolute difference and saturating sums
    always_comb begin
        s1_res   = s1_valid_reg && (s1_item_reg.eof || s1_item_reg.mismatch);
        prev     = s1_item_reg.use_prev ? rd_data : s1_item_reg.pix;
        diff     = (s1_item_reg.pix > prev) ? (s1_item_reg.pix - prev)
                                            : (prev - s1_item_reg.pix);
        even_add = {1'b0, even_reg} + (SUM_W + 1)'(diff);
        odd_add  = {1'b0, odd_reg} + (SUM_W + 1)'(diff);
        even_sat = (even_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : even_add[SUM_W-1:0];
        odd_sat  = (odd_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : odd_add[SUM_W-1:0];

        even_next = even_reg;
        odd_next  = odd_reg;
        if (s1_valid_reg && !s1_item_reg.mismatch && s1_item_reg.counted) begin
            if (s1_item_reg.odd_row) begin
                odd_next = odd_sat;
            end else begin
                even_next = even_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            even_reg <= '0;
            odd_reg  <= '0;
        end else if (s1_valid_reg && s1_item_reg.eof && !s1_item_reg.mismatch) begin
            even_reg <= '0;
            odd_reg  <= '0;
        end else begin
            even_reg <= even_next;
            odd_reg  <= odd_next;
        end
    end

    // result formed in the accumulate stage
    always_comb begin
        res_frame = s1_item_reg.frame;
        if (s1_item_reg.mismatch) begin
            res_even   = '0;
            res_odd    = '0;
            res_status = STATUS_SEQ_FAIL;
        end else begin
            res_even   = even_next;
            res_odd    = odd_next;
            res_status = STATUS_OK;
        end
    end

    // two-entry output buffer: head drives the stream, spare entry catches overflow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_pop) begin
            m_valid_reg  <= sk_valid_reg || s1_res;
            sk_valid_reg <= sk_valid_reg && s1_res;
        end else begin
            sk_valid_reg <= sk_valid_reg || s1_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_pop) begin
            if (sk_valid_reg) begin
                m_frame_reg  <= sk_frame_reg;
                m_even_reg   <= sk_even_reg;
                m_odd_reg    <= sk_odd_reg;
                m_status_reg <= sk_status_reg;
            end else if (s1_res) begin
                m_frame_reg  <= res_frame;
                m_even_reg   <= res_even;
                m_odd_reg    <= res_odd;
                m_status_reg <= res_status;
            end
        end
        if (s1_res && (sk_valid_reg || (m_valid_reg && !m_pop))) begin
            sk_frame_reg  <= res_frame;
            sk_even_reg   <= res_even;
            sk_odd_reg    <= res_odd;
            sk_status_reg <= res_status;
        end
    end

    always_comb begin
        m_tvalid   = m_valid_reg;
        m_tdata    = M_DATA_W'({m_odd_reg, m_even_reg, m_frame_reg});
        m_tuser[0] = m_status_reg;
    end

    // a result never arrives while both buffer entries stay full
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_res |-> !(m_valid_reg && sk_valid_reg && !m_tready))
        else $error("result slot overwritten");

    // an error result means the block is halted
    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STATUS_SEQ_FAIL) |-> halted)
        else $error("error result without halt");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted |=> halted)
        else $error("halt released");

    // nothing reaches the accumulate stage once halted
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(halted) && halted |-> !s1_valid_reg)
        else $error("byte processed while halted");

endmodule

`default_nettype wire

FILE: bench/field_delta_measure_core_tb.sv
`default_nettype none

module field_delta_measure_core_tb;
    import fdm_pkg::*;

    localparam int unsigned MAX_W_DIM    = 1024;
    localparam int unsigned MAX_H_DIM    = 1024;
    localparam int unsigned STORE_BYTES  = 3145728;
    localparam int unsigned RGB_BYTES    = 3;
    localparam int unsigned IDLE_PCT     = 22;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned RANDOM_ITEMS = 150;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned REPORT_LIMIT = 10;

    // one finished frame as it leaves on the result stream
    typedef struct packed {
        logic [NUM_W-1:0] frame;
        logic [SUM_W-1:0] even;
        logic [SUM_W-1:0] odd;
        logic             status;
    } delta_result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // block ports
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;   // pixel_byte, frame_number, zero pad
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;          // result_frame, even_delta, odd_delta, zero pad
    logic [0:0]           m_tuser;          // status

    field_delta_measure_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // register copies seen by the predictor
    logic [DIM_W-1:0] reg_width  = WIDTH_RESET;
    logic [DIM_W-1:0] reg_height = HEIGHT_RESET;
    logic             reg_format = FMT_YUV420;

    // predictor state
    logic [PIX_W-1:0] frame_store [int unsigned];
    bit               first_frame    = 1'b1;
    logic [NUM_W-1:0] next_frame_num = '0;
    int unsigned      scan_pos       = 0;
    int unsigned      scan_row       = 0;
    int unsigned      scan_col       = 0;
    bit               in_chroma      = 1'b0;
    logic [SUM_W-1:0] sum_even       = '0;
    logic [SUM_W-1:0] sum_odd        = '0;
    bit               seq_halted     = 1'b0;

    delta_result_t expected_sums [$];

    // traffic shaping
    int unsigned src_idle_pct  = IDLE_PCT;
    int unsigned snk_idle_pct  = IDLE_PCT;
    int unsigned hold_length   = 0;
    int unsigned hold_orders   = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    bit          flip_pattern  = 1'b0;
    int unsigned mismatch_count = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input int unsigned d);
        int unsigned s;
        s = acc + d;
        return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // bytes in one frame under the current registers
    function automatic int unsigned frame_len();
        int unsigned w, h, n;
        w = clamp_dim(reg_width, MAX_W_DIM);
        h = clamp_dim(reg_height, MAX_H_DIM);
        if (reg_format == FMT_RGB24) return RGB_BYTES * w * h;
        n = w * h;
        for (int unsigned r = 0; r < h; r++)
            n += (w >> 1) + ((((w & 1) != 0) && ((r & 1) != 0)) ? 1 : 0);
        return n;
    endfunction

    // field sums for one accepted byte, queues a result at frame end
    task automatic predict_byte(input logic [PIX_W-1:0] pix, input logic [NUM_W-1:0] num);
        int unsigned   w, h, rowlen, half, diff;
        logic [PIX_W-1:0] prev;
        bit            rgb, counted;
        delta_result_t res;
        if (seq_halted) return;
        w = clamp_dim(reg_width, MAX_W_DIM);
        h = clamp_dim(reg_height, MAX_H_DIM);
        rgb = (reg_format == FMT_RGB24);

        // frame number check on the first byte
        if (scan_pos == 0) begin
            if (first_frame) next_frame_num = num;
            if (num != next_frame_num) begin
                seq_halted = 1'b1;
                res.frame = next_frame_num;
                res.even = '0;
                res.odd = '0;
                res.status = STATUS_SEQ_FAIL;
                expected_sums.push_back(res);
                return;
            end
        end

        // row length and whether this byte counts
        if (rgb) begin
            rowlen = RGB_BYTES * w;
            counted = 1'b1;
        end else if (!in_chroma) begin
            rowlen = w;
            counted = 1'b1;
        end else begin
            half = w >> 1;
            rowlen = half + ((((w & 1) != 0) && ((scan_row & 1) != 0)) ? 1 : 0);
            counted = (scan_col < half);
        end

        // compare with the previous frame and store
        if (scan_pos < STORE_BYTES) begin
            if (first_frame) prev = pix;
            else if (frame_store.exists(scan_pos)) prev = frame_store[scan_pos];
            else prev = '0;
            frame_store[scan_pos] = pix;
        end else begin
            prev = pix;
        end
        diff = (pix > prev) ? (pix - prev) : (prev - pix);
        if (counted) begin
            if ((scan_row & 1) != 0) sum_odd = sat_add(sum_odd, diff);
            else sum_even = sat_add(sum_even, diff);
        end

        // advance position, close the frame after the last row
        scan_pos++;
        scan_col++;
        if (scan_col >= rowlen) begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= h) begin
                scan_row = 0;
                if (rgb || in_chroma) begin
                    res.frame = next_frame_num;
                    res.even = sum_even;
                    res.odd = sum_odd;
                    res.status = STATUS_OK;
                    expected_sums.push_back(res);
                    sum_even = '0;
                    sum_odd = '0;
                    scan_pos = 0;
                    in_chroma = 1'b0;
                    first_frame = 1'b0;
                    next_frame_num = next_frame_num + 1'b1;
                    return;
                end
                in_chroma = 1'b1;
            end
        end
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [PIX_W-1:0] pix, input logic [NUM_W-1:0] num);
        @(negedge aclk);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W - PIX_W - NUM_W){1'b0}}, num, pix};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_byte(pix, num);
    endtask

    // whole frame, either random bytes or alternating 0 / 255 flipped per frame
    task automatic send_frame(input logic [NUM_W-1:0] first_num, input bit extremes);
        int unsigned      n, i;
        logic [PIX_W-1:0] pix;
        logic [NUM_W-1:0] num;
        n = frame_len();
        if (extremes) flip_pattern = !flip_pattern;
        for (i = 0; i < n; i++) begin
            if (extremes) begin
                pix = ((((i & 1) != 0) ^ flip_pattern) != 0) ? '1 : '0;
            end else begin
                case ($urandom_range(0, 7))
                    0: pix = '0;
                    1: pix = '1;
                    default: pix = PIX_W'($urandom);
                endcase
            end
            num = (i == 0) ? first_num : NUM_W'($urandom);
            send_byte(pix, num);
        end
    endtask

    // wait for the block to go idle, then write all three registers
    task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic fmt);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(negedge aclk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(negedge aclk);
        cfg_index <= CFG_PIXEL_FORMAT;
        cfg_data <= {{(DIM_W - 1){1'b0}}, fmt};
        @(negedge aclk);
        cfg_we <= 1'b0;
        reg_width = w;
        reg_height = h;
        reg_format = fmt;
    endtask

    // first frame is as large as any frame of the run and is compared with itself
    task automatic test_first_frame_wide();
        configure(11'd9, 11'd9, FMT_RGB24);
        send_frame({NUM_W{1'b1}}, 1'b0);
    endtask

    // narrow tall frame, frame number wraps to zero
    task automatic test_tall_frame();
        configure(11'd2, 11'd9, FMT_YUV420);
        send_frame(next_frame_num, 1'b0);
    endtask

    // widths and heights below two, full-swing bytes
    task automatic test_dimension_clamp_low();
        configure(11'd0, 11'd1, FMT_RGB24);
        send_frame(next_frame_num, 1'b1);
        send_frame(next_frame_num, 1'b1);
        configure(11'd1, 11'd0, FMT_YUV420);
        send_frame(next_frame_num, 1'b1);
        send_frame(next_frame_num, 1'b1);
    endtask

    // odd width: odd chroma rows carry one extra byte that is not summed
    task automatic test_odd_width_chroma();
        configure(11'd3, 11'd3, FMT_YUV420);
        send_frame(next_frame_num, 1'b1);
        send_frame(next_frame_num, 1'b1);
        configure(11'd5, 11'd2, FMT_YUV420);
        send_frame(next_frame_num, 1'b0);
        send_frame(next_frame_num, 1'b1);
    endtask

    // receiver holds off while small frames keep coming, block must stall input
    task automatic test_output_backpressure();
        int unsigned k;
        configure(11'd2, 11'd2, FMT_YUV420);
        src_idle_pct = 0;
        @(posedge aclk);
        hold_length = HOLD_CYCLES;
        hold_orders++;
        for (k = 0; k < 12; k++) send_frame(next_frame_num, 1'b0);
        src_idle_pct = IDLE_PCT;
    endtask

    // random sizes and formats, a few frames per setting
    task automatic test_random_frames();
        int unsigned sent, phase, frames, k;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            // every fourth setting, starting with the first, runs with both sides always ready
            if (phase % 4 == 0) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = IDLE_PCT;
                snk_idle_pct = IDLE_PCT;
            end
            configure(DIM_W'($urandom_range(0, 9)), DIM_W'($urandom_range(0, 9)),
                      1'($urandom_range(0, 1)));
            frames = (phase % 4 == 0) ? 8 : $urandom_range(1, 4);
            for (k = 0; k < frames && sent < RANDOM_ITEMS; k++) begin
                sent += frame_len();
                send_frame(next_frame_num, $urandom_range(0, 5) == 0);
            end
            phase++;
        end
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
    endtask

    // wrong frame number halts the block, later bytes give nothing
    task automatic test_sequence_error();
        int unsigned      k;
        logic [NUM_W-1:0] wrong;
        configure(11'd4, 11'd2, FMT_RGB24);
        wrong = next_frame_num + NUM_W'($urandom_range(1, 1000));
        send_byte(PIX_W'($urandom), wrong);
        for (k = 0; k < 16; k++)
            send_byte(PIX_W'($urandom), (k == 0) ? next_frame_num : NUM_W'($urandom));
    endtask

    // result side ready, with random idles and ordered hold-off stretches
    always @(negedge aclk) begin : result_sink
        if (hold_served != hold_orders) begin
            hold_served <= hold_orders;
            hold_left <= hold_length;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic flag_error(input string msg);
        if (mismatch_count < REPORT_LIMIT) $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        delta_result_t got, want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.frame = m_tdata[NUM_W-1:0];
            got.even = m_tdata[NUM_W +: SUM_W];
            got.odd = m_tdata[NUM_W + SUM_W +: SUM_W];
            got.status = m_tuser[0];
            if (expected_sums.size() == 0) begin
                flag_error($sformatf("unexpected result frame %0d even %0d odd %0d status %0b",
                                     got.frame, got.even, got.odd, got.status));
            end else begin
                want = expected_sums.pop_front();
                if (got.frame !== want.frame || got.even !== want.even ||
                    got.odd !== want.odd || got.status !== want.status) begin
                    flag_error($sformatf(
                        {"frame exp %0d got %0d, even exp %0d got %0d, ",
                         "odd exp %0d got %0d, status exp %0b got %0b"},
                        want.frame, got.frame, want.even, got.even,
                        want.odd, got.odd, want.status, got.status));
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_first_frame_wide();
        test_tall_frame();
        test_dimension_clamp_low();
        test_odd_width_chroma();
        test_output_backpressure();
        test_random_frames();
        test_sequence_error();

        // let the last results drain
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("field_delta_measure_core verification clean");
        end else begin
            $display("field_delta_measure_core verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("field_delta_measure_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
